### rtl/core/hkc_pkg.sv
// ============================================================================
// hkc_pkg - shared types and constants of the hash keystream cipher
// SHA-256 constants, register map, queue item and config structs.
// ============================================================================
package hkc_pkg;

    // message length counter width (bytes, wraps)
    localparam int LEN_BITS = 32;

    // front queue depth
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // register map (index = paddr[5:3])
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_SALTU = 3'd4;
    localparam logic [2:0] REG_SALTL = 3'd5;
    localparam logic [2:0] REG_DMODE = 3'd6;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // queued request from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;  // opens a new message
    } t_q_item;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] salt_u;
        logic [31:0] salt_l;
        logic        dmode;
    } t_cfg;

    typedef struct packed {
        logic start;
    } t_sha_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sha_sts;

    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/hkc_front.sv
// ============================================================================
// hkc_front - input side of the cipher
// Accepts bytes, marks the first byte of each message, queues requests.
// ============================================================================
module hkc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_q_valid,
    output hkc_pkg::t_q_item  o_q_head,
    input  logic              i_q_pop
);

    hkc_pkg::t_q_item                  r_ent [hkc_pkg::QDEPTH];
    logic [hkc_pkg::QPTR_W-1:0]        r_wr;
    logic [hkc_pkg::QPTR_W-1:0]        r_rd;
    logic [hkc_pkg::QCNT_W-1:0]        r_cnt;
    logic                              r_next_first;
    logic                              w_acc;
    logic                              w_pop;

    assign o_full    = (r_cnt == hkc_pkg::QCNT_W'(hkc_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_head  = r_ent[r_rd];
    assign w_acc     = i_push && !o_full;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr         <= '0;
            r_rd         <= '0;
            r_cnt        <= '0;
            r_next_first <= 1'b1;
        end else begin
            if (w_acc) begin
                r_wr         <= (r_wr == hkc_pkg::QPTR_W'(hkc_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
                r_next_first <= i_last_byte;
            end
            if (w_pop) begin
                r_rd <= (r_rd == hkc_pkg::QPTR_W'(hkc_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_acc && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_acc && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ent[r_wr] <= '{data: i_data_byte, last: i_last_byte, first: r_next_first};
        end
    end

endmodule

### rtl/core/hkc_sha_core.sv
// ============================================================================
// hkc_sha_core - iterative SHA-256 compression
// One round per cycle, 64 rounds; digest valid in the done cycle.
// ============================================================================
module hkc_sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkc_pkg::t_sha_ctl  i_ctl,
    input  logic [255:0]       i_h,
    input  logic [511:0]       i_blk,
    output hkc_pkg::t_sha_sts  o_sts,
    output logic [255:0]       o_h
);

    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [31:0]  r_w [16];
    logic [255:0] r_hin;
    logic [5:0]   r_rnd;
    logic         r_busy;
    logic         r_done;

    logic [31:0]  w_t1, w_t2, w_wn, w_s0, w_s1;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        w_t1 = r_hh + (rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25))
             + ((r_e & r_f) ^ (~r_e & r_g)) + hkc_pkg::sha_k(r_rnd) + r_w[0];
        w_t2 = (rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22))
             + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
        w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wn = r_w[0] + w_s0 + r_w[9] + w_s1;
    end

    assign o_sts = '{busy: r_busy, done: r_done};
    assign o_h   = {r_hin[255:224] + r_a,  r_hin[223:192] + r_b,
                    r_hin[191:160] + r_c,  r_hin[159:128] + r_d,
                    r_hin[127:96]  + r_e,  r_hin[95:64]   + r_f,
                    r_hin[63:32]   + r_g,  r_hin[31:0]    + r_hh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 1'b1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_hin <= i_h;
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh} <= i_h;
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_blk[511 - 32*i -: 32];
            end
        end else if (r_busy) begin
            r_hh <= r_g;
            r_g  <= r_f;
            r_f  <= r_e;
            r_e  <= r_d + w_t1;
            r_d  <= r_c;
            r_c  <= r_b;
            r_b  <= r_a;
            r_a  <= w_t1 + w_t2;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wn;
        end
    end

endmodule

### rtl/core/hkc_back.sv
// ============================================================================
// hkc_back - execution side of the cipher
// Sequences base, keystream and tag compressions; holds the result register.
// ============================================================================
module hkc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkc_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  hkc_pkg::t_q_item   i_q_head,
    output logic               o_q_pop,
    output hkc_pkg::t_sha_ctl  o_sha_ctl,
    output logic [255:0]       o_sha_h,
    output logic [511:0]       o_sha_blk,
    input  hkc_pkg::t_sha_sts  i_sha_sts,
    input  logic [255:0]       i_sha_h,
    output logic               o_valid,
    input  logic               i_take,
    output logic [7:0]         o_result_byte,
    output logic               o_is_last,
    output logic [63:0]        o_tag
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_BASE   = 11'b00000000010,
        ST_KSGO   = 11'b00000000100,
        ST_KS     = 11'b00000001000,
        ST_XOR    = 11'b00000010000,
        ST_TAGC   = 11'b00000100000,
        ST_FIN    = 11'b00001000000,
        ST_FINA   = 11'b00010000000,
        ST_FINBGO = 11'b00100000000,
        ST_FINB   = 11'b01000000000,
        ST_EMIT   = 11'b10000000000
    } t_state;

    t_state                         r_state;
    logic [255:0]                   r_base;
    logic [255:0]                   r_ks;
    logic [255:0]                   r_chain;
    logic [511:0]                   r_buf;
    logic [255:0]                   r_h;
    logic [511:0]                   r_fblk;
    logic [31:0]                    r_idx;
    logic [4:0]                     r_pos;
    logic [hkc_pkg::LEN_BITS-1:0]   r_len;
    logic [7:0]                     r_dout;
    logic                           r_last;
    logic [63:0]                    r_tag;
    logic                           r_ovalid;
    logic [7:0]                     r_obyte;
    logic                           r_olast;
    logic [63:0]                    r_otag;

    logic [5:0]   w_fill;
    logic [7:0]   w_ksb;
    logic [7:0]   w_dout;
    logic [7:0]   w_plain;
    logic [511:0] w_buf_wr;
    logic [511:0] w_finblk;
    logic [63:0]  w_bits;
    logic [31:0]  w_idx_n;
    logic [351:0] w_prefix;
    logic         w_emit;

    assign w_fill   = r_len[5:0] + 6'd44;
    assign w_ksb    = r_ks[{~r_pos, 3'b111} -: 8];
    assign w_dout   = i_q_head.data ^ w_ksb;
    assign w_plain  = i_cfg.dmode ? w_dout : i_q_head.data;
    assign w_bits   = (64'(r_len) + 64'd44) << 3;
    assign w_idx_n  = r_idx + 32'd1;
    assign w_prefix = {i_cfg.key0, i_cfg.key1, i_cfg.key2, i_cfg.key3,
                       i_cfg.salt_u, i_cfg.salt_l};
    assign w_emit   = (r_state == ST_EMIT) && (!r_ovalid || i_take);

    always_comb begin
        w_buf_wr = r_buf;
        w_buf_wr[{~w_fill, 3'b111} -: 8] = w_plain;
        w_finblk = r_buf;
        w_finblk[{~w_fill, 3'b111} -: 8] = 8'h80;
    end

    // compression unit input select
    always_comb begin
        o_sha_ctl = '{start: 1'b0};
        o_sha_h   = r_h;
        o_sha_blk = r_fblk;
        unique case (r_state)
            ST_IDLE: begin
                o_sha_h   = hkc_pkg::SHA_IV;
                o_sha_blk = {w_prefix, 8'h80, 88'b0, 64'd352};
                o_sha_ctl = '{start: i_q_valid && i_q_head.first};
            end
            ST_KSGO: begin
                o_sha_h   = hkc_pkg::SHA_IV;
                o_sha_blk = {r_base, w_idx_n[7:0], w_idx_n[15:8], w_idx_n[23:16],
                             w_idx_n[31:24], 8'h80, 152'b0, 64'd288};
                o_sha_ctl = '{start: 1'b1};
            end
            ST_XOR: begin
                o_sha_h   = r_chain;
                o_sha_blk = w_buf_wr;
                o_sha_ctl = '{start: w_fill == 6'd63};
            end
            ST_FIN: begin
                o_sha_h   = r_chain;
                o_sha_blk = w_finblk;
                o_sha_ctl = '{start: w_fill >= 6'd56};
            end
            ST_FINBGO: begin
                o_sha_ctl = '{start: 1'b1};
            end
            default: begin
                o_sha_ctl = '{start: 1'b0};
            end
        endcase
    end

    assign o_q_pop = (r_state == ST_XOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_take && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_head.first) begin
                            r_state <= ST_BASE;
                        end else if (r_pos == '0) begin
                            r_state <= ST_KSGO;
                        end else begin
                            r_state <= ST_XOR;
                        end
                    end
                end
                ST_BASE:   if (i_sha_sts.done) r_state <= ST_KSGO;
                ST_KSGO:   r_state <= ST_KS;
                ST_KS:     if (i_sha_sts.done) r_state <= ST_XOR;
                ST_XOR: begin
                    if (w_fill == 6'd63) begin
                        r_state <= ST_TAGC;
                    end else begin
                        r_state <= i_q_head.last ? ST_FIN : ST_EMIT;
                    end
                end
                ST_TAGC:   if (i_sha_sts.done) r_state <= r_last ? ST_FIN : ST_EMIT;
                ST_FIN:    r_state <= (w_fill >= 6'd56) ? ST_FINA : ST_FINBGO;
                ST_FINA:   if (i_sha_sts.done) r_state <= ST_FINBGO;
                ST_FINBGO: r_state <= ST_FINB;
                ST_FINB:   if (i_sha_sts.done) r_state <= ST_EMIT;
                ST_EMIT:   if (w_emit) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_BASE: begin
                if (i_sha_sts.done) begin
                    r_base  <= i_sha_h;
                    r_chain <= hkc_pkg::SHA_IV;
                    r_buf   <= {w_prefix, 160'b0};
                    r_len   <= '0;
                    r_idx   <= '0;
                    r_pos   <= '0;
                end
            end
            ST_KSGO: r_idx <= w_idx_n;
            ST_KS:   if (i_sha_sts.done) r_ks <= i_sha_h;
            ST_XOR: begin
                r_dout <= w_dout;
                r_last <= i_q_head.last;
                r_pos  <= r_pos + 1'b1;
                r_len  <= r_len + 1'b1;
                r_tag  <= '0;
                if (w_fill != 6'd63) begin
                    r_buf <= w_buf_wr;
                end
            end
            ST_TAGC: begin
                if (i_sha_sts.done) begin
                    r_chain <= i_sha_h;
                    r_buf   <= '0;
                end
            end
            ST_FIN: begin
                r_h <= r_chain;
                if (w_fill >= 6'd56) begin
                    r_fblk <= {448'b0, w_bits};
                end else begin
                    r_fblk <= {w_finblk[511:64], w_bits};
                end
            end
            ST_FINA: if (i_sha_sts.done) r_h <= i_sha_h;
            ST_FINB: if (i_sha_sts.done) r_tag <= i_sha_h[255:192];
            default: ;
        endcase
        if (w_emit) begin
            r_obyte <= r_dout;
            r_olast <= r_last;
            r_otag  <= r_last ? r_tag : 64'd0;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_result_byte = r_obyte;
    assign o_is_last     = r_olast;
    assign o_tag         = r_otag;

endmodule

### rtl/core/hash_keystream_cipher_with_tag.sv
// ============================================================================
// hash_keystream_cipher_with_tag - SHA-256 keystream byte cipher with tag
// Bytes are XORed with a hash keystream; a second hash yields a 64-bit tag.
// ============================================================================
//
//  channel   handshake                      payload
//  -------   ----------------------------   ------------------------------
//  input     push / full                    i_data_byte, i_last_byte
//  result    empty / pop                    o_result_byte, o_is_last, o_tag
//  config    psel/penable/pwrite, pready=1  paddr (8*index), pwdata, prdata
//
//  Compressions: a SHA-256 compression runs 64 rounds, one per cycle, plus
//  start and done; a byte without a compression passes the idle, XOR and
//  emit states. Every 32nd byte adds a keystream compression and every 64th
//  a tag compression; the shared round unit sets the byte rate. The first
//  byte of a message adds the base digest, the last byte one or two tag
//  compressions.
//  Reset: synchronous, active low; config registers clear, queues empty.
//  Stalls: a 2-deep request queue takes bytes while the result register
//  waits for pop.
//
module hash_keystream_cipher_with_tag (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // results
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_result_byte,
    output logic        o_is_last,
    output logic [63:0] o_tag,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    hkc_pkg::t_cfg      r_cfg;
    hkc_pkg::t_q_item   w_q_head;
    hkc_pkg::t_sha_ctl  w_sha_ctl;
    hkc_pkg::t_sha_sts  w_sha_sts;
    logic               w_q_valid;
    logic               w_q_pop;
    logic [255:0]       w_sha_hin;
    logic [511:0]       w_sha_blk;
    logic [255:0]       w_sha_hout;
    logic               w_valid;
    logic               w_wr;
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[5:3];

    // register writes; key and salt are sampled by the back end on a first byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                hkc_pkg::REG_KEY0:  r_cfg.key0   <= pwdata;
                hkc_pkg::REG_KEY1:  r_cfg.key1   <= pwdata;
                hkc_pkg::REG_KEY2:  r_cfg.key2   <= pwdata;
                hkc_pkg::REG_KEY3:  r_cfg.key3   <= pwdata;
                hkc_pkg::REG_SALTU: r_cfg.salt_u <= pwdata;
                hkc_pkg::REG_SALTL: r_cfg.salt_l <= pwdata[31:0];
                hkc_pkg::REG_DMODE: r_cfg.dmode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            hkc_pkg::REG_KEY0:  prdata = r_cfg.key0;
            hkc_pkg::REG_KEY1:  prdata = r_cfg.key1;
            hkc_pkg::REG_KEY2:  prdata = r_cfg.key2;
            hkc_pkg::REG_KEY3:  prdata = r_cfg.key3;
            hkc_pkg::REG_SALTU: prdata = r_cfg.salt_u;
            hkc_pkg::REG_SALTL: prdata = {32'b0, r_cfg.salt_l};
            hkc_pkg::REG_DMODE: prdata = {63'b0, r_cfg.dmode};
            default:            prdata = 64'd0;
        endcase
    end

    // front: accept and tag message starts
    hkc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_q_valid   (w_q_valid),
        .o_q_head    (w_q_head),
        .i_q_pop     (w_q_pop)
    );

    // shared compression unit
    hkc_sha_core u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sha_ctl),
        .i_h     (w_sha_hin),
        .i_blk   (w_sha_blk),
        .o_sts   (w_sha_sts),
        .o_h     (w_sha_hout)
    );

    // back: sequencing and result register
    hkc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_head      (w_q_head),
        .o_q_pop       (w_q_pop),
        .o_sha_ctl     (w_sha_ctl),
        .o_sha_h       (w_sha_hin),
        .o_sha_blk     (w_sha_blk),
        .i_sha_sts     (w_sha_sts),
        .i_sha_h       (w_sha_hout),
        .o_valid       (w_valid),
        .i_take        (pop),
        .o_result_byte (o_result_byte),
        .o_is_last     (o_is_last),
        .o_tag         (o_tag)
    );

    assign empty = !w_valid;

endmodule

### rtl/core/hkc_checker.sv
// ============================================================================
// hkc_checker - port-level checks of the cipher
// Watches the top level's ports; attached by bind.
// ============================================================================
module hkc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_is_last,
    input logic [63:0] o_tag,
    input logic        pready
);

    // results queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");

    // tag is zero on every result but the last
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_is_last) |-> (o_tag == 64'd0))
        else $error("tag nonzero on a non-final result");

    // config port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    // a waiting result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result lost without pop");

endmodule

bind hash_keystream_cipher_with_tag hkc_checker u_hkc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .empty     (empty),
    .pop       (pop),
    .o_is_last (o_is_last),
    .o_tag     (o_tag),
    .pready    (pready)
);

### bench/cipher_tag_checker.sv
// ============================================================================
// cipher_tag_checker - result predictor and comparator for the cipher
// Tracks config writes, predicts keystream bytes and tags, compares results.
// ============================================================================
module cipher_tag_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_result_byte,
    input  logic        o_is_last,
    input  logic [63:0] o_tag,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0]  rbyte;
        logic        last;
        logic [63:0] tag;
    } t_cipher_out;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [255:0] INIT_CHAIN = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    hkc_pkg::t_cfg cfg;
    logic [255:0] base_dig, ks_block, chain;
    logic [511:0] tag_buf;
    logic [31:0]  blk_idx, msg_len;
    logic [4:0]   pos;
    logic         in_msg;
    t_cipher_out  expected_results [$];

    assign o_pending = expected_results.size();

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression, block byte 0 in the top bits
    function automatic logic [255:0] sha_compress(input logic [255:0] hin,
                                                  input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        logic [255:0] hout;
        for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hin[255-32*i -: 32];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hout[255-32*i -: 32] = hin[255-32*i -: 32] + v[i];
        return hout;
    endfunction

    // advance the cipher model by one request, queue its expected result
    task automatic predict_cipher_byte(input logic [7:0] din, input logic last);
        logic [351:0] prefix;
        logic [7:0]   dout, plain;
        logic [5:0]   fill;
        logic [511:0] blk;
        logic [255:0] h;
        logic [63:0]  bits;
        t_cipher_out  r;
        if (!in_msg) begin
            // key and salt latched at message start
            prefix   = {cfg.key0, cfg.key1, cfg.key2, cfg.key3, cfg.salt_u, cfg.salt_l};
            base_dig = sha_compress(INIT_CHAIN, {prefix, 8'h80, 88'd0, 64'd352});
            chain    = INIT_CHAIN;
            tag_buf  = {prefix, 160'd0};
            msg_len  = '0;
            blk_idx  = '0;
            pos      = '0;
            in_msg   = 1'b1;
        end
        if (pos == 0) begin
            blk_idx  = blk_idx + 1;
            ks_block = sha_compress(INIT_CHAIN, {base_dig, blk_idx[7:0], blk_idx[15:8],
                                    blk_idx[23:16], blk_idx[31:24], 8'h80, 152'd0, 64'd288});
        end
        dout  = din ^ ks_block[255-8*pos -: 8];
        pos   = pos + 1;
        plain = cfg.dmode ? dout : din;
        fill  = 6'(44 + msg_len);
        tag_buf[511-8*fill -: 8] = plain;
        if (fill == 63) begin
            chain   = sha_compress(chain, tag_buf);
            tag_buf = '0;
        end
        msg_len = msg_len + 1;
        r = '{rbyte: dout, last: last, tag: 64'd0};
        if (last) begin
            bits = (64'd44 + 64'(msg_len)) * 64'd8;
            fill = 6'(44 + msg_len);
            h    = chain;
            blk  = tag_buf;
            blk[511-8*fill -: 8] = 8'h80;
            for (int i = fill + 1; i < 64; i++) blk[511-8*i -: 8] = 8'h00;
            if (fill >= 56) begin
                h   = sha_compress(h, blk);
                blk = '0;
            end
            blk[63:0] = bits;
            h = sha_compress(h, blk);
            r.tag  = h[255:192];
            in_msg = 1'b0;
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_cipher_out e;
        if (!i_rst_n) begin
            cfg      <= '0;
            base_dig = '0; ks_block = '0; chain = INIT_CHAIN; tag_buf = '0;
            blk_idx  = '0; msg_len = '0; pos = '0; in_msg = 1'b0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: byte %h", o_result_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_byte !== e.rbyte || o_is_last !== e.last
                            || o_tag !== e.tag)
                        o_fail_count <= o_fail_count + 1;
                    if (o_result_byte !== e.rbyte)
                        $error("result_byte: expected %h got %h", e.rbyte, o_result_byte);
                    if (o_is_last !== e.last)
                        $error("is_last: expected %b got %b", e.last, o_is_last);
                    if (o_tag !== e.tag)
                        $error("tag: expected %h got %h", e.tag, o_tag);
                end
            end
            if (push && !full)
                predict_cipher_byte(i_data_byte, i_last_byte);
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    hkc_pkg::REG_KEY0:  cfg.key0   <= pwdata;
                    hkc_pkg::REG_KEY1:  cfg.key1   <= pwdata;
                    hkc_pkg::REG_KEY2:  cfg.key2   <= pwdata;
                    hkc_pkg::REG_KEY3:  cfg.key3   <= pwdata;
                    hkc_pkg::REG_SALTU: cfg.salt_u <= pwdata;
                    hkc_pkg::REG_SALTL: cfg.salt_l <= pwdata[31:0];
                    hkc_pkg::REG_DMODE: cfg.dmode  <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### bench/tb_hash_keystream_cipher_with_tag.sv
// ============================================================================
// tb_hash_keystream_cipher_with_tag - testbench top for the cipher block
// Drives messages and config writes with random gaps and stalls; the checker
// predicts every result byte and tag and counts mismatches.
// ============================================================================
module tb_hash_keystream_cipher_with_tag;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_result_byte;
    logic        o_is_last;
    logic [63:0] o_tag;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count, pending;
    logic        quiet = 1'b0;    // no idling in the closing phase
    int          idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    hash_keystream_cipher_with_tag dut (.*);

    cipher_tag_checker chk (
        .i_clk, .i_rst_n, .push, .full, .i_data_byte, .i_last_byte,
        .empty, .pop, .o_result_byte, .o_is_last, .o_tag,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending));

    // watchdog: cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_hash_keystream_cipher_with_tag: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: one long hold-off early so the request queue backs up,
    // then random stall bursts, none once quiet
    initial begin
        @(posedge i_rst_n);
        repeat (300) @(negedge i_clk);
        pop <= 1'b0;
        repeat (600) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // setup + access cycle; register written on the access edge
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic cfg_all(input logic [63:0] k0, k1, k2, k3, su,
                           input logic [31:0] sl, input logic dm);
        cfg_write(hkc_pkg::REG_KEY0, k0);
        cfg_write(hkc_pkg::REG_KEY1, k1);
        cfg_write(hkc_pkg::REG_KEY2, k2);
        cfg_write(hkc_pkg::REG_KEY3, k3);
        cfg_write(hkc_pkg::REG_SALTU, su);
        cfg_write(hkc_pkg::REG_SALTL, {32'd0, sl});
        cfg_write(hkc_pkg::REG_DMODE, {63'd0, dm});
    endtask

    // returns at the edge where the request was taken
    task automatic send_byte(input logic [7:0] d, input logic last);
        @(negedge i_clk);
        push <= 1'b1; i_data_byte <= d; i_last_byte <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                i_data_byte <= 8'($urandom);
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end
            send_byte(8'($urandom), i == len - 1);
        end
    endtask

    // sender stops until every expected result is back, then settles
    task automatic drain;
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64;
        return {32'($urandom), 32'($urandom)};
    endfunction

    initial begin
        int budget;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset config: single-byte messages at the data extremes,
        // a length that pushes the length field into an extra tag block
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_message(12);
        send_message(8);
        drain();

        // all-ones key and salt, decrypt side
        cfg_all('1, '1, '1, '1, '1, '1, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        send_message(19);
        drain();

        // random settings; the last phase runs without idling
        for (int ph = 0; ph < 5; ph++) begin
            cfg_all(rand64(), rand64(), rand64(), rand64(), rand64(),
                    32'($urandom), 1'($urandom));
            quiet = (ph == 4);
            budget = 200;
            while (budget > 0) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140)
                                                  : $urandom_range(1, 40);
                send_message(len);
                budget -= len;
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_hash_keystream_cipher_with_tag: clean");
        end else begin
            $display("tb_hash_keystream_cipher_with_tag: errors");
        end
        $finish;
    end

endmodule
